// ===== hdl/hrp_pkg.sv =====
package hrp_pkg;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_ADDR_HI = 3'd2;
  localparam logic [2:0] PH_ADDR_LO = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_CHK     = 3'd6;

  localparam logic [2:0] K_DATA     = 3'd0;
  localparam logic [2:0] K_DONE     = 3'd1;
  localparam logic [2:0] K_NOSTART  = 3'd2;
  localparam logic [2:0] K_BADDIGIT = 3'd3;
  localparam logic [2:0] K_TRUNC    = 3'd4;

  localparam logic [7:0] START_MARK     = 8'h3A;
  localparam logic [3:0] MAX_SKIP_RESET = 4'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       last_in_buffer;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic        checksum_ok;
  } out_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        second_nibble;
    logic [3:0]  high_nibble;
    logic [3:0]  skip_count;
    logic [7:0]  length_reg;
    logic [15:0] address_reg;
    logic [7:0]  type_reg;
    logic [7:0]  bytes_seen;
    logic [7:0]  running_sum;
  } state_t;

endpackage

// ===== hdl/hex_record_parser.sv =====
// Intel HEX record parser taking one ASCII character per word. A character is
// accepted every cycle as long as results are taken; each accepted character
// gives zero or one result word: it is held in the input register, then the
// parser step (a state update with an 8-bit checksum add) writes the result
// register. No clearing pass is needed after reset. While a result waits, the
// input register can still take one character, then the input side stalls
// until it is taken. The user must write max_skip_chars (reset 3) through
// cfg_write_en/cfg_write_data only while the block is idle (not enforced).
module hex_record_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic [3:0]    cfg_write_data,
  input  logic          char_valid,
  output logic          char_ready,
  input  hrp_pkg::in_t  char_word,
  output logic          result_valid,
  input  logic          result_ready,
  output hrp_pkg::out_t result_word
);

  logic            hold_valid;
  hrp_pkg::in_t    hold_word;
  hrp_pkg::state_t st;
  hrp_pkg::state_t st_next;
  logic [3:0]      max_skip_chars;
  logic            step_valid;
  hrp_pkg::out_t   step_res;
  logic            out_free;
  logic            advance;

  hrp_step u_step (
    .st             (st),
    .max_skip_chars (max_skip_chars),
    .word           (hold_word),
    .nxt            (st_next),
    .res_valid      (step_valid),
    .res            (step_res)
  );

  assign out_free   = !result_valid || result_ready;
  assign advance    = hold_valid && out_free;
  assign char_ready = !hold_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      result_valid   <= 1'b0;
      st             <= '0;
      max_skip_chars <= hrp_pkg::MAX_SKIP_RESET;
    end else begin
      if (cfg_write_en) begin
        max_skip_chars <= cfg_write_data;
      end
      if (char_ready) begin
        hold_valid <= char_valid;
      end
      if (advance) begin
        st           <= st_next;
        result_valid <= step_valid;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      hold_word <= char_word;
    end
    if (advance && step_valid) begin
      result_word <= step_res;
    end
  end

endmodule

// ===== hdl/hrp_step.sv =====
module hrp_step (
  input  hrp_pkg::state_t st,
  input  logic [3:0]      max_skip_chars,
  input  hrp_pkg::in_t    word,
  output hrp_pkg::state_t nxt,
  output logic            res_valid,
  output hrp_pkg::out_t   res
);

  logic       digit_ok;
  logic [3:0] digit;
  logic [7:0] ch;
  logic [7:0] full_byte;
  logic [7:0] seen_inc;

  assign ch = word.character;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (ch > 8'd47 && ch < 8'd58) begin
      digit = ch[3:0];
    end else if ((ch > 8'd64 && ch < 8'd71) || (ch > 8'd96 && ch < 8'd103)) begin
      // letters a-f / A-F: low bits 1..6 map to 10..15
      digit = ch[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign full_byte = {st.high_nibble, digit};
  assign seen_inc  = st.bytes_seen + 8'd1;

  always_comb begin
    nxt       = st;
    res_valid = 1'b0;
    res       = '0;
    if (st.phase == hrp_pkg::PH_HUNT) begin
      if (ch == hrp_pkg::START_MARK) begin
        nxt.phase         = hrp_pkg::PH_LEN;
        nxt.second_nibble = 1'b0;
        nxt.skip_count    = 4'd0;
        nxt.running_sum   = 8'd0;
        nxt.bytes_seen    = 8'd0;
        nxt.length_reg    = 8'd0;
        nxt.address_reg   = 16'd0;
        nxt.type_reg      = 8'd0;
      end else if (st.skip_count >= max_skip_chars) begin
        res_valid      = 1'b1;
        res.kind       = hrp_pkg::K_NOSTART;
        nxt.skip_count = 4'd0;
      end else begin
        nxt.skip_count = st.skip_count + 4'd1;
      end
    end else if (!digit_ok) begin
      res_valid         = 1'b1;
      res.kind          = hrp_pkg::K_BADDIGIT;
      nxt.phase         = hrp_pkg::PH_HUNT;
      nxt.second_nibble = 1'b0;
      nxt.skip_count    = 4'd0;
    end else if (!st.second_nibble) begin
      nxt.high_nibble   = digit;
      nxt.second_nibble = 1'b1;
    end else begin
      nxt.second_nibble = 1'b0;
      nxt.running_sum   = st.running_sum + full_byte;
      case (st.phase)
        hrp_pkg::PH_LEN: begin
          nxt.length_reg = full_byte;
          nxt.phase      = hrp_pkg::PH_ADDR_HI;
        end
        hrp_pkg::PH_ADDR_HI: begin
          nxt.address_reg = {full_byte, 8'd0};
          nxt.phase       = hrp_pkg::PH_ADDR_LO;
        end
        hrp_pkg::PH_ADDR_LO: begin
          nxt.address_reg = {st.address_reg[15:8], full_byte};
          nxt.phase       = hrp_pkg::PH_TYPE;
        end
        hrp_pkg::PH_TYPE: begin
          nxt.type_reg = full_byte;
          nxt.phase    = (st.length_reg == 8'd0) ? hrp_pkg::PH_CHK : hrp_pkg::PH_DATA;
        end
        hrp_pkg::PH_DATA: begin
          res_valid         = 1'b1;
          res.kind          = hrp_pkg::K_DATA;
          res.byte_address  = st.address_reg + {8'd0, st.bytes_seen};
          res.data_byte     = full_byte;
          res.record_type   = st.type_reg;
          res.record_length = st.length_reg;
          nxt.bytes_seen    = seen_inc;
          if (seen_inc == st.length_reg) begin
            nxt.phase = hrp_pkg::PH_CHK;
          end
        end
        default: begin
          res_valid         = 1'b1;
          res.kind          = hrp_pkg::K_DONE;
          res.byte_address  = st.address_reg;
          res.data_byte     = full_byte;
          res.record_type   = st.type_reg;
          res.record_length = st.length_reg;
          res.checksum_ok   = (nxt.running_sum == 8'd0);
          nxt.phase         = hrp_pkg::PH_HUNT;
          nxt.skip_count    = 4'd0;
        end
      endcase
    end

    if (word.last_in_buffer) begin
      if (nxt.phase != hrp_pkg::PH_HUNT) begin
        res_valid         = 1'b1;
        res               = '0;
        res.kind          = hrp_pkg::K_TRUNC;
        nxt.phase         = hrp_pkg::PH_HUNT;
        nxt.second_nibble = 1'b0;
      end
      nxt.skip_count = 4'd0;
    end
  end

endmodule

// ===== hdl/hrp_checker.sv =====
module hrp_checker (
  input logic          clk,
  input logic          rst,
  input logic          char_ready,
  input logic          result_valid,
  input logic          result_ready,
  input hrp_pkg::out_t result_word
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("result word dropped or changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> char_ready)
    else $error("input not ready after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_word.kind <= hrp_pkg::K_TRUNC)
    else $error("result kind out of range");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_word.kind == hrp_pkg::K_NOSTART ||
                     result_word.kind == hrp_pkg::K_BADDIGIT ||
                     result_word.kind == hrp_pkg::K_TRUNC)
    |-> result_word.byte_address == 16'd0 && result_word.data_byte == 8'd0 &&
        result_word.record_type == 8'd0 && result_word.record_length == 8'd0 &&
        !result_word.checksum_ok)
    else $error("error result carries record fields");

  a_data_no_checksum: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.kind == hrp_pkg::K_DATA
    |-> !result_word.checksum_ok && result_word.record_length != 8'd0)
    else $error("data byte result with bad fields");

endmodule

bind hex_record_parser hrp_checker u_hrp_checker (
  .clk          (clk),
  .rst          (rst),
  .char_ready   (char_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_word  (result_word)
);

// ===== dv/hex_record_checker.sv =====
`timescale 1ns / 1ps

module hex_record_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic  [3:0]   cfg_write_data,
  input  logic          char_valid,
  input  logic          char_ready,
  input  hrp_pkg::in_t  char_word,
  input  logic          result_valid,
  input  logic          result_ready,
  input  hrp_pkg::out_t result_word,
  output int            mismatches,
  output int            outstanding
);

  logic [3:0]    max_skip;
  logic [2:0]    ph;
  logic          second_nib;
  logic [3:0]    high_nib;
  logic [3:0]    skips;
  logic [7:0]    rec_len;
  logic [15:0]   rec_addr;
  logic [7:0]    rec_type;
  logic [7:0]    data_count;
  logic [7:0]    sum8;
  hrp_pkg::out_t due_results[$];
  int            words_seen;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd16;
    if (c >= "0" && c <= "9") begin
      t = c - "0";
    end else if (c >= "A" && c <= "F") begin
      t = c - 8'd55;
    end else if (c >= "a" && c <= "f") begin
      t = c - 8'd87;
    end
    return t[4:0];
  endfunction

  task automatic back_to_hunt();
    ph = hrp_pkg::PH_HUNT;
    second_nib = 1'b0;
    skips = 4'd0;
  endtask

  task automatic parse_char(input hrp_pkg::in_t w);
    logic [4:0]    d;
    logic [7:0]    b;
    hrp_pkg::out_t r;
    bit            emit;
    emit = 1'b0;
    r = '0;
    if (ph == hrp_pkg::PH_HUNT) begin
      if (w.character == hrp_pkg::START_MARK) begin
        ph = hrp_pkg::PH_LEN;
        second_nib = 1'b0;
        skips = 4'd0;
        sum8 = 8'd0;
        data_count = 8'd0;
        rec_len = 8'd0;
        rec_addr = 16'd0;
        rec_type = 8'd0;
      end else if (skips >= max_skip) begin
        r.kind = hrp_pkg::K_NOSTART;
        emit = 1'b1;
        skips = 4'd0;
      end else begin
        skips = skips + 4'd1;
      end
    end else begin
      d = hex_value(w.character);
      if (d[4]) begin
        r.kind = hrp_pkg::K_BADDIGIT;
        emit = 1'b1;
        back_to_hunt();
      end else if (!second_nib) begin
        high_nib = d[3:0];
        second_nib = 1'b1;
      end else begin
        b = {high_nib, d[3:0]};
        second_nib = 1'b0;
        sum8 = sum8 + b;
        case (ph)
          hrp_pkg::PH_LEN: begin
            rec_len = b;
            ph = hrp_pkg::PH_ADDR_HI;
          end
          hrp_pkg::PH_ADDR_HI: begin
            rec_addr = {b, 8'h00};
            ph = hrp_pkg::PH_ADDR_LO;
          end
          hrp_pkg::PH_ADDR_LO: begin
            rec_addr[7:0] = b;
            ph = hrp_pkg::PH_TYPE;
          end
          hrp_pkg::PH_TYPE: begin
            rec_type = b;
            ph = (rec_len == 8'd0) ? hrp_pkg::PH_CHK : hrp_pkg::PH_DATA;
          end
          hrp_pkg::PH_DATA: begin
            r.kind = hrp_pkg::K_DATA;
            r.byte_address = rec_addr + {8'h00, data_count};
            r.data_byte = b;
            r.record_type = rec_type;
            r.record_length = rec_len;
            emit = 1'b1;
            data_count = data_count + 8'd1;
            if (data_count == rec_len) ph = hrp_pkg::PH_CHK;
          end
          default: begin
            r.kind = hrp_pkg::K_DONE;
            r.byte_address = rec_addr;
            r.data_byte = b;
            r.record_type = rec_type;
            r.record_length = rec_len;
            r.checksum_ok = (sum8 == 8'd0);
            emit = 1'b1;
            back_to_hunt();
          end
        endcase
      end
    end
    if (w.last_in_buffer) begin
      if (ph != hrp_pkg::PH_HUNT) begin
        r = '0;
        r.kind = hrp_pkg::K_TRUNC;
        emit = 1'b1;
        back_to_hunt();
      end
      skips = 4'd0;
    end
    if (emit) due_results.push_back(r);
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    hrp_pkg::out_t want;
    if (rst) begin
      mismatches = 0;
      words_seen = 0;
      max_skip = hrp_pkg::MAX_SKIP_RESET;
      high_nib = 4'd0;
      rec_len = 8'd0;
      rec_addr = 16'd0;
      rec_type = 8'd0;
      data_count = 8'd0;
      sum8 = 8'd0;
      back_to_hunt();
      due_results.delete();
    end else begin
      if (cfg_write_en) max_skip = cfg_write_data;
      if (result_valid && result_ready) begin
        words_seen++;
        if (due_results.size() == 0) begin
          flag($sformatf("result word %0d unexpected: kind %0d addr %h data %h",
                         words_seen, result_word.kind, result_word.byte_address,
                         result_word.data_byte));
        end else begin
          want = due_results.pop_front();
          if (result_word.kind !== want.kind ||
              result_word.byte_address !== want.byte_address ||
              result_word.data_byte !== want.data_byte ||
              result_word.record_type !== want.record_type ||
              result_word.record_length !== want.record_length ||
              result_word.checksum_ok !== want.checksum_ok) begin
            flag($sformatf({"result word %0d (exp/got): kind %0d/%0d addr %h/%h ",
                            "data %h/%h type %h/%h len %h/%h ok %0d/%0d"},
                           words_seen, want.kind, result_word.kind,
                           want.byte_address, result_word.byte_address,
                           want.data_byte, result_word.data_byte,
                           want.record_type, result_word.record_type,
                           want.record_length, result_word.record_length,
                           want.checksum_ok, result_word.checksum_ok));
          end
        end
      end
      if (char_valid && char_ready) parse_char(char_word);
    end
    outstanding = due_results.size();
  end

endmodule

// ===== dv/tb_hex_record_parser.sv =====
`timescale 1ns / 1ps

module tb_hex_record_parser;

  logic          clk;
  logic          rst;
  logic          cfg_write_en;
  logic [3:0]    cfg_write_data;
  logic          char_valid;
  logic          char_ready;
  hrp_pkg::in_t  char_word;
  logic          result_valid;
  logic          result_ready;
  hrp_pkg::out_t result_word;
  int            mismatches;
  int            outstanding;

  bit          no_gaps;
  int          sent;
  int          skip_limit;
  int unsigned stall_left;
  logic [7:0]  rec_bytes[$];
  logic [7:0]  rec_chars[$];

  hex_record_parser uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .char_word      (char_word),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_word    (result_word)
  );

  hex_record_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .char_word      (char_word),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_word    (result_word),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + {4'h0, n};
    if ($urandom_range(0, 1) == 0) return "A" + {4'h0, n} - 8'd10;
    return "a" + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 5))
          0: return 8'd47;
          1: return 8'd58;
          2: return 8'd64;
          3: return 8'd71;
          4: return 8'd96;
          default: return 8'd103;
        endcase
      end
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom_range(0, 47));
      3: return 8'($urandom_range(103, 127));
      default: return hrp_pkg::START_MARK;
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == hrp_pkg::START_MARK) c = "#";
    return c;
  endfunction

  // result side stalls
  initial begin
    result_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    char_word <= '{character: ch, last_in_buffer: last};
    do @(posedge clk); while (!char_ready);
    sent++;
  endtask

  task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] rtype, input bit good_sum,
                             input int cut_at, input int bad_at);
    logic [7:0] sum;
    int i;
    rec_bytes.delete();
    rec_bytes.push_back(len);
    rec_bytes.push_back(addr[15:8]);
    rec_bytes.push_back(addr[7:0]);
    rec_bytes.push_back(rtype);
    for (i = 0; i < len; i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    sum = 8'd0;
    foreach (rec_bytes[j]) sum = sum + rec_bytes[j];
    rec_bytes.push_back(good_sum ? 8'd0 - sum : 8'($urandom_range(0, 255)));
    rec_chars.delete();
    rec_chars.push_back(hrp_pkg::START_MARK);
    foreach (rec_bytes[j]) begin
      rec_chars.push_back(hex_char(rec_bytes[j][7:4]));
      rec_chars.push_back(hex_char(rec_bytes[j][3:0]));
    end
    for (i = 0; i < rec_chars.size(); i++) begin
      if (i == bad_at) begin
        send_char(bad_char(), 1'b0);
        break;
      end
      send_char(rec_chars[i], i == cut_at);
      if (i == cut_at) break;
    end
  endtask

  task automatic send_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned r;
    int          len;
    int          nchars;
    int          cut;
    int          bad;
    logic [15:0] addr;
    logic [7:0]  rtype;
    no_gaps = ($urandom_range(0, 99) < 20);
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      n = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(0, skip_limit + 2);
      repeat (n) send_char(junk_char(), $urandom_range(0, 99) < 5);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 4);
      else if (r < 95) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 64);
      addr = ($urandom_range(0, 99) < 30) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                          : 16'($urandom_range(0, 16'hFFFF));
      rtype = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 5))
                                          : 8'($urandom_range(0, 255));
      nchars = 11 + 2 * len;
      cut = -1;
      bad = -1;
      if (pick < 70) begin
        r = $urandom_range(0, 99);
        if (r < 12) cut = $urandom_range(0, nchars - 1);
        else if (r < 20) cut = nchars - 1;
      end else begin
        bad = $urandom_range(1, nchars - 1);
      end
      send_record(len[7:0], addr, rtype, $urandom_range(0, 99) < 80, cut, bad);
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 8);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    char_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_skip(input logic [3:0] v);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    skip_limit = int'(v);
  endtask

  initial begin
    int         p;
    logic [3:0] v;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = 4'd0;
    char_valid = 1'b0;
    char_word = '0;
    no_gaps = 1'b0;
    sent = 0;
    skip_limit = int'(hrp_pkg::MAX_SKIP_RESET);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // junk past the skip limit, buffer end while hunting
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'd47, 1'b0);
    send_char(8'd64, 1'b0);
    send_char(8'd96, 1'b0);
    send_char(8'd103, 1'b1);
    // start mark and bad digits inside a record
    send_char(hrp_pkg::START_MARK, 1'b0);
    send_char(hrp_pkg::START_MARK, 1'b0);
    send_char(hrp_pkg::START_MARK, 1'b0);
    send_char("G", 1'b0);
    // record cut off by buffer end
    send_char(hrp_pkg::START_MARK, 1'b0);
    send_char("0", 1'b1);
    // zero length end-of-file record
    send_record(8'd0, 16'h0000, 8'h01, 1'b1, -1, -1);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: v = 4'd0;
        1: v = 4'd15;
        4: v = 4'd3;
        default: v = 4'($urandom_range(0, 15));
      endcase
      write_max_skip(v);
      if (p == 2) send_record(8'd255, 16'($urandom_range(0, 16'hFFFF)), 8'h00, 1'b1, -1, -1);
      while (sent < 23 + (p + 1) * 225) send_sequence();
    end

    no_gaps = 1'b0;
    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
